// ===== hw/rtl/pcac_pkg.sv =====
// shared types, constants and codes for the checkerboard alpha compositor
// no dependencies; compiled first
`timescale 1ns / 1ps

package pcac_pkg;

   // screen geometry and checker grid
   localparam int SCREEN_DIM    = 4096;
   localparam int CHECK_CELL_W  = 8;
   localparam int GRID_SHIFT    = $clog2(CHECK_CELL_W);
   localparam int COORD_W       = 12;

   // field widths
   localparam int ZOOM_W  = 23;
   localparam int FMT_W   = 2;
   localparam int PIXEL_W = 32;
   localparam int CHAN_W  = 8;
   localparam int NCHAN   = PIXEL_W / CHAN_W;

   // control register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_ZOOM   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FORMAT = 2'd1;

   // pixel format codes
   localparam logic [FMT_W-1:0] FMT_GRAY  = 2'd0;
   localparam logic [FMT_W-1:0] FMT_BGR   = 2'd1;
   localparam logic [FMT_W-1:0] FMT_BGRA  = 2'd2;
   localparam logic [FMT_W-1:0] FMT_UNSUP = 2'd3;

   // reset values of the control registers
   localparam logic [ZOOM_W-1:0] ZOOM_UNITY  = ZOOM_W'(1 << 16);
   localparam logic [FMT_W-1:0]  FMT_RESET   = FMT_BGRA;

   // fixed colors
   localparam logic [CHAN_W-1:0] CHECK_DARK   = 8'd40;
   localparam logic [CHAN_W-1:0] CHECK_LIGHT  = 8'd60;
   localparam logic [CHAN_W-1:0] OOB_GREY     = 8'd70;
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
   localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'd0;

   // one input word
   typedef struct packed {
      logic [COORD_W-1:0] screen_x;
      logic [COORD_W-1:0] screen_y;
      logic               in_bounds;
      logic               src_col_zero;
      logic               src_row_zero;
      logic [PIXEL_W-1:0] px_cur;
      logic [PIXEL_W-1:0] px_left;
      logic [PIXEL_W-1:0] px_up;
      logic [PIXEL_W-1:0] px_up_left;
      logic [CHAN_W-1:0]  px_edge;
   } req_word_type;

   // one result word
   typedef struct packed {
      logic [CHAN_W-1:0] out_blue;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_alpha;
   } rsp_word_type;

   // live configuration handed to the datapath
   typedef struct packed {
      logic [ZOOM_W-1:0] zoom_level;
      logic [FMT_W-1:0]  pixel_format;
   } cfg_type;

endpackage

// ===== hw/rtl/pcac_if.sv =====
// valid/ready channel interfaces for the compositor: request, response, control writes
// depends on pcac_pkg
`timescale 1ns / 1ps

// request channel: one screen pixel with its source neighborhood
interface pcac_req_if import pcac_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] screen_x;
   logic [COORD_W-1:0] screen_y;
   logic               in_bounds;
   logic               src_col_zero;
   logic               src_row_zero;
   logic [PIXEL_W-1:0] px_cur;
   logic [PIXEL_W-1:0] px_left;
   logic [PIXEL_W-1:0] px_up;
   logic [PIXEL_W-1:0] px_up_left;
   logic [CHAN_W-1:0]  px_edge;

   modport source (output valid, screen_x, screen_y, in_bounds, src_col_zero,
                   src_row_zero, px_cur, px_left, px_up, px_up_left, px_edge,
                   input ready);
   modport sink   (input valid, screen_x, screen_y, in_bounds, src_col_zero,
                   src_row_zero, px_cur, px_left, px_up, px_up_left, px_edge,
                   output ready);
endinterface

// response channel: one BGRA display pixel
interface pcac_rsp_if import pcac_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] out_blue;
   logic [CHAN_W-1:0] out_green;
   logic [CHAN_W-1:0] out_red;
   logic [CHAN_W-1:0] out_alpha;

   modport source (output valid, out_blue, out_green, out_red, out_alpha, input ready);
   modport sink   (input valid, out_blue, out_green, out_red, out_alpha, output ready);
endinterface

// control register write channel
interface pcac_csr_if import pcac_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/pcac_pixel.sv =====
// pixel datapath: box/edge averaging, checker background and alpha blend
// depends on pcac_pkg; purely combinational, sits between the stage registers
`timescale 1ns / 1ps

module pcac_pixel import pcac_pkg::*; (
   input  req_word_type req_word,
   input  cfg_type      cfg,
   output rsp_word_type rsp_word
);

   logic                shrink;
   logic                box;
   logic [COORD_W-1:0]  x_wrap;
   logic [COORD_W-1:0]  y_wrap;
   logic [CHAN_W-1:0]   bg;
   logic [CHAN_W-1:0]   p [NCHAN];
   logic [CHAN_W+1:0]   box_sum [NCHAN];
   logic [CHAN_W:0]     gray_sum;
   logic [CHAN_W-1:0]   gray;
   logic [CHAN_W-1:0]   alpha;
   logic [CHAN_W-1:0]   inv_alpha;
   logic [2*CHAN_W-1:0] mix [3];

   // averaging enables
   assign shrink = cfg.zoom_level < ZOOM_UNITY;
   assign box    = shrink && !req_word.src_row_zero && !req_word.src_col_zero;

   // checker cell from wrapped screen coordinates
   assign x_wrap = COORD_W'(32'(req_word.screen_x) % SCREEN_DIM);
   assign y_wrap = COORD_W'(32'(req_word.screen_y) % SCREEN_DIM);
   assign bg     = (x_wrap[GRID_SHIFT] ^ y_wrap[GRID_SHIFT]) ? CHECK_DARK : CHECK_LIGHT;

   // 2x2 box average per channel, truncating
   always_comb begin
      for (int i = 0; i < NCHAN; i++) begin
         box_sum[i] = (CHAN_W+2)'(req_word.px_cur[i*CHAN_W +: CHAN_W])
                    + (CHAN_W+2)'(req_word.px_left[i*CHAN_W +: CHAN_W])
                    + (CHAN_W+2)'(req_word.px_up[i*CHAN_W +: CHAN_W])
                    + (CHAN_W+2)'(req_word.px_up_left[i*CHAN_W +: CHAN_W]);
         p[i] = box ? box_sum[i][CHAN_W+1:2] : req_word.px_cur[i*CHAN_W +: CHAN_W];
      end
   end

   // gray edge average with the single neighbor
   assign gray_sum = (CHAN_W+1)'(req_word.px_cur[CHAN_W-1:0]) + (CHAN_W+1)'(req_word.px_edge);
   assign gray     = (shrink && !box) ? gray_sum[CHAN_W:1] : p[0];

   // blend over the checker, divide by 256
   assign alpha     = p[3];
   assign inv_alpha = ALPHA_OPAQUE - alpha;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mix[i] = (2*CHAN_W)'(bg) * (2*CHAN_W)'(inv_alpha)
                + (2*CHAN_W)'(p[i]) * (2*CHAN_W)'(alpha);
      end
   end

   // format select
   always_comb begin
      rsp_word = '{out_blue: bg, out_green: bg, out_red: bg, out_alpha: ALPHA_OPAQUE};
      if (!req_word.in_bounds) begin
         rsp_word = '{out_blue: OOB_GREY, out_green: OOB_GREY, out_red: OOB_GREY,
                      out_alpha: ALPHA_OPAQUE};
      end else begin
         case (cfg.pixel_format)
            FMT_GRAY: begin
               rsp_word = '{out_blue: gray, out_green: gray, out_red: gray,
                            out_alpha: ALPHA_OPAQUE};
            end
            FMT_BGR: begin
               rsp_word = '{out_blue: p[0], out_green: p[1], out_red: p[2],
                            out_alpha: ALPHA_OPAQUE};
            end
            FMT_BGRA: begin
               if (alpha == ALPHA_CLEAR) begin
                  rsp_word = '{out_blue: bg, out_green: bg, out_red: bg,
                               out_alpha: ALPHA_OPAQUE};
               end else if (alpha == ALPHA_OPAQUE) begin
                  rsp_word = '{out_blue: p[0], out_green: p[1], out_red: p[2],
                               out_alpha: ALPHA_OPAQUE};
               end else begin
                  rsp_word = '{out_blue: mix[0][2*CHAN_W-1:CHAN_W],
                               out_green: mix[1][2*CHAN_W-1:CHAN_W],
                               out_red: mix[2][2*CHAN_W-1:CHAN_W],
                               out_alpha: alpha};
               end
            end
            FMT_UNSUP: begin
               rsp_word = '{out_blue: bg, out_green: bg, out_red: bg, out_alpha: ALPHA_OPAQUE};
            end
            default: begin
               rsp_word = '{out_blue: bg, out_green: bg, out_red: bg, out_alpha: ALPHA_OPAQUE};
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/pcac_csr.sv =====
// control registers: zoom level and pixel format
// depends on pcac_pkg and pcac_if
`timescale 1ns / 1ps

module pcac_csr import pcac_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   pcac_csr_if.sink csr_chan,
   output cfg_type cfg
);

   logic [ZOOM_W-1:0] zoom_ff, zoom_in;
   logic [FMT_W-1:0]  fmt_ff, fmt_in;
   logic              wr_en;

   // writes always taken; unknown indexes are dropped
   assign csr_chan.ready = 1'b1;
   assign wr_en          = csr_chan.valid && csr_chan.ready;

   always_comb begin
      zoom_in = zoom_ff;
      fmt_in  = fmt_ff;
      if (wr_en) begin
         case (csr_chan.index)
            CSR_ZOOM:   zoom_in = csr_chan.data[ZOOM_W-1:0];
            CSR_FORMAT: fmt_in  = csr_chan.data[FMT_W-1:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zoom_ff <= ZOOM_UNITY;
         fmt_ff  <= FMT_RESET;
      end else begin
         zoom_ff <= zoom_in;
         fmt_ff  <= fmt_in;
      end
   end

   assign cfg = '{zoom_level: zoom_ff, pixel_format: fmt_ff};

   // a write to an unknown index leaves both registers alone
   a_unknown_index_ignored: assert property (@(posedge clock) disable iff (reset)
      wr_en && csr_chan.index != CSR_ZOOM && csr_chan.index != CSR_FORMAT
      |=> $stable(zoom_ff) && $stable(fmt_ff))
      else $error("control write to unknown index changed a register");

   // registers come out of reset at their defaults
   a_reset_values: assert property (@(posedge clock)
      $past(reset) |-> zoom_ff == ZOOM_UNITY && fmt_ff == FMT_RESET)
      else $error("control registers not at reset values");

   // zoom register takes the low bits of a zoom write
   a_zoom_write: assert property (@(posedge clock) disable iff (reset)
      wr_en && csr_chan.index == CSR_ZOOM |=> zoom_ff == $past(csr_chan.data[ZOOM_W-1:0]))
      else $error("zoom write not captured");

endmodule

// ===== hw/rtl/pixel_checkerboard_alpha_compositor.sv =====
// Checkerboard alpha compositor with 2x2 box downsample.
//
// Channels: req_chan carries one screen pixel per word with the source pixel,
// its left, up and up-left neighbors and a gray edge neighbor; rsp_chan returns
// one BGRA display pixel per word; csr_chan writes zoom_level (index 0) and
// pixel_format (index 1), and is always ready. Write config only while idle.
//
// Path: an accepted word goes through the input register, then the result
// register behind the pixel datapath, before it is shown on rsp_chan.
// Throughput: one word per clock unless rsp_chan stalls, via the combinational
// datapath; req_chan.ready stays high while the result register drains.
// When the receiver stalls, the result register holds its word and the input
// register fills behind it; req_chan.ready drops only when both are full.
// Reset (synchronous, active high) empties both registers and sets zoom to
// 1.0 (65536) and the format to BGRA.
// Depends on pcac_pkg, pcac_if, pcac_csr and pcac_pixel.
`timescale 1ns / 1ps

module pixel_checkerboard_alpha_compositor import pcac_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pcac_req_if.sink   req_chan,
   pcac_rsp_if.source rsp_chan,
   pcac_csr_if.sink   csr_chan
);

   cfg_type      cfg;
   logic         s1_valid_ff, s1_valid_in;
   req_word_type s1_word_ff, s1_word_in;
   logic         s2_valid_ff, s2_valid_in;
   rsp_word_type s2_word_ff, s2_word_in;
   rsp_word_type calc_word;
   logic         s2_free;
   logic         s1_adv;
   logic         req_take;

   // control registers
   pcac_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // pipeline flow control
   assign s2_free        = !s2_valid_ff || rsp_chan.ready;
   assign s1_adv         = s1_valid_ff && s2_free;
   assign req_chan.ready = !s1_valid_ff || s2_free;
   assign req_take       = req_chan.valid && req_chan.ready;

   // input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_word_in  = s1_word_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_word_in  = '{screen_x: req_chan.screen_x, screen_y: req_chan.screen_y,
                         in_bounds: req_chan.in_bounds,
                         src_col_zero: req_chan.src_col_zero,
                         src_row_zero: req_chan.src_row_zero,
                         px_cur: req_chan.px_cur, px_left: req_chan.px_left,
                         px_up: req_chan.px_up, px_up_left: req_chan.px_up_left,
                         px_edge: req_chan.px_edge};
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // pixel datapath
   pcac_pixel u_pixel (
      .req_word (s1_word_ff),
      .cfg      (cfg),
      .rsp_word (calc_word)
   );

   // result register
   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_word_in  = s2_word_ff;
      if (s1_adv) begin
         s2_valid_in = 1'b1;
         s2_word_in  = calc_word;
      end else if (s2_valid_ff && rsp_chan.ready) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_ff <= s1_word_in;
      s2_word_ff <= s2_word_in;
   end

   // response outputs
   assign rsp_chan.valid     = s2_valid_ff;
   assign rsp_chan.out_blue  = s2_word_ff.out_blue;
   assign rsp_chan.out_green = s2_word_ff.out_green;
   assign rsp_chan.out_red   = s2_word_ff.out_red;
   assign rsp_chan.out_alpha = s2_word_ff.out_alpha;

   // input side blocks only when both registers are full and the output stalls
   a_ready_when_room: assert property (@(posedge clock) disable iff (reset)
      !(s1_valid_ff && s2_valid_ff && !rsp_chan.ready) |-> req_chan.ready)
      else $error("request refused while pipeline has room");

   // a word held in the input register is not lost while it waits
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_word_ff))
      else $error("input register dropped a waiting word");

   // a word moving to the result register fills it
   a_s2_fills: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> s2_valid_ff)
      else $error("result register not loaded on advance");

   // out of bounds pixels always leave as the background grey
   a_oob_grey: assert property (@(posedge clock) disable iff (reset)
      s1_adv && !s1_word_ff.in_bounds |=> s2_word_ff.out_red == OOB_GREY
         && s2_word_ff.out_alpha == ALPHA_OPAQUE)
      else $error("out of bounds pixel not grey");

endmodule

// ===== bench/pixel_checkerboard_alpha_compositor_tb.sv =====
// testbench for pixel_checkerboard_alpha_compositor: directed and random pixel words checked
// against an in-bench compositing predictor, with random stalls on both channels
// depends on pcac_pkg, pcac_if and the compositor rtl
`timescale 1ns / 1ps

module pixel_checkerboard_alpha_compositor_tb;
   import pcac_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 1525;
   localparam int PRESSURE_RUN  = 40;
   localparam int LONG_HOLD     = 150;
   localparam int SETTLE_CYCLES = 4;
   localparam int MAX_REPORTS   = 10;
   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   // predicts display pixels and checks them in arrival order
   class pixel_scoreboard;
      rsp_word_type      expected_pixels[$];
      logic [ZOOM_W-1:0] zoom_level;
      logic [FMT_W-1:0]  pixel_format;
      int                mismatches;

      function new();
         zoom_level   = ZOOM_UNITY;
         pixel_format = FMT_RESET;
         mismatches   = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_ZOOM:   zoom_level   = value[ZOOM_W-1:0];
            CSR_FORMAT: pixel_format = value[FMT_W-1:0];
            default: ;
         endcase
      endfunction

      function rsp_word_type composite(req_word_type w);
         logic [CHAN_W-1:0] bg;
         logic [CHAN_W-1:0] p[NCHAN];
         logic              shrink;
         logic              box;
         int                acc;
         int                a;
         int                c[3];
         // checker cell parity from the 8-pixel grid
         bg     = (w.screen_x[GRID_SHIFT] ^ w.screen_y[GRID_SHIFT]) ? CHECK_DARK : CHECK_LIGHT;
         shrink = zoom_level < ZOOM_UNITY;
         box    = shrink && !w.src_row_zero && !w.src_col_zero;
         if (!w.in_bounds)
            return {OOB_GREY, OOB_GREY, OOB_GREY, ALPHA_OPAQUE};
         // truncating 2x2 box per channel
         for (int k = 0; k < NCHAN; k++) begin
            if (box)
               acc = (w.px_cur[CHAN_W*k +: CHAN_W] + w.px_left[CHAN_W*k +: CHAN_W] +
                      w.px_up[CHAN_W*k +: CHAN_W] + w.px_up_left[CHAN_W*k +: CHAN_W]) / 4;
            else
               acc = w.px_cur[CHAN_W*k +: CHAN_W];
            p[k] = acc[CHAN_W-1:0];
         end
         case (pixel_format)
            FMT_GRAY: begin
               acc = p[0];
               // gray at the top row or left column pairs with its edge neighbor
               if (shrink && !box)
                  acc = (w.px_cur[CHAN_W-1:0] + w.px_edge) / 2;
               return {acc[CHAN_W-1:0], acc[CHAN_W-1:0], acc[CHAN_W-1:0], ALPHA_OPAQUE};
            end
            FMT_BGR:
               return {p[0], p[1], p[2], ALPHA_OPAQUE};
            FMT_BGRA: begin
               if (p[3] == ALPHA_CLEAR)
                  return {bg, bg, bg, ALPHA_OPAQUE};
               if (p[3] == ALPHA_OPAQUE)
                  return {p[0], p[1], p[2], ALPHA_OPAQUE};
               a = p[3];
               for (int k = 0; k < 3; k++)
                  c[k] = (bg * (255 - a) + p[k] * a) / 256;
               return {c[0][CHAN_W-1:0], c[1][CHAN_W-1:0], c[2][CHAN_W-1:0], p[3]};
            end
            default:
               return {bg, bg, bg, ALPHA_OPAQUE};
         endcase
      endfunction

      function void note_request(req_word_type w);
         expected_pixels.push_back(composite(w));
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type want;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected pixel b=%0d g=%0d r=%0d a=%0d",
                        got.out_blue, got.out_green, got.out_red, got.out_alpha);
            return;
         end
         want = expected_pixels.pop_front();
         if (got.out_blue !== want.out_blue || got.out_green !== want.out_green ||
             got.out_red !== want.out_red || got.out_alpha !== want.out_alpha) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("pixel mismatch: expected b=%0d g=%0d r=%0d a=%0d, got b=%0d g=%0d r=%0d a=%0d",
                        want.out_blue, want.out_green, want.out_red, want.out_alpha,
                        got.out_blue, got.out_green, got.out_red, got.out_alpha);
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   pcac_req_if req_bus();
   pcac_rsp_if rsp_bus();
   pcac_csr_if csr_bus();

   pixel_checkerboard_alpha_compositor dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   pixel_scoreboard board;
   bit              req_idling = 1'b1;
   bit              rsp_idling = 1'b1;
   int              long_hold_cycles = 0;
   int              cycle_count = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle length: mostly short, a few long
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_word_type pixel_word(
      logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic inb, logic col0, logic row0,
      logic [PIXEL_W-1:0] cur, logic [PIXEL_W-1:0] lft, logic [PIXEL_W-1:0] up,
      logic [PIXEL_W-1:0] upl, logic [CHAN_W-1:0] edge_px);
      req_word_type w;
      w.screen_x     = x;
      w.screen_y     = y;
      w.in_bounds    = inb;
      w.src_col_zero = col0;
      w.src_row_zero = row0;
      w.px_cur       = cur;
      w.px_left      = lft;
      w.px_up        = up;
      w.px_up_left   = upl;
      w.px_edge      = edge_px;
      return w;
   endfunction

   // random pixel word, alpha biased toward clear, opaque and near-extreme values
   function automatic req_word_type random_request();
      req_word_type w;
      int           amode;
      w = pixel_word(COORD_W'($urandom), COORD_W'($urandom), $urandom_range(0, 9) != 0,
                     $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0,
                     $urandom, $urandom, $urandom, $urandom, CHAN_W'($urandom));
      amode = $urandom_range(0, 5);
      case (amode)
         0: begin
            w.px_cur[31:24] = ALPHA_CLEAR;  w.px_left[31:24]    = ALPHA_CLEAR;
            w.px_up[31:24]  = ALPHA_CLEAR;  w.px_up_left[31:24] = ALPHA_CLEAR;
         end
         1: begin
            w.px_cur[31:24] = ALPHA_OPAQUE; w.px_left[31:24]    = ALPHA_OPAQUE;
            w.px_up[31:24]  = ALPHA_OPAQUE; w.px_up_left[31:24] = ALPHA_OPAQUE;
         end
         2: w.px_cur[31:24] = $urandom_range(0, 1) ? 8'd1 : 8'd254;
         default: ;
      endcase
      return w;
   endfunction

   // offer one pixel word and wait for its handshake
   task automatic send_pixel(input req_word_type w);
      int gap;
      gap = (req_idling && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
      @(negedge clock);
      req_bus.valid        = 1'b1;
      req_bus.screen_x     = w.screen_x;
      req_bus.screen_y     = w.screen_y;
      req_bus.in_bounds    = w.in_bounds;
      req_bus.src_col_zero = w.src_col_zero;
      req_bus.src_row_zero = w.src_row_zero;
      req_bus.px_cur       = w.px_cur;
      req_bus.px_left      = w.px_left;
      req_bus.px_up        = w.px_up;
      req_bus.px_up_left   = w.px_up_left;
      req_bus.px_edge      = w.px_edge;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      board.note_request(w);
   endtask

   // stop offering and wait until every expected pixel is back
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = index;
      csr_bus.data  = value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      board.write_register(index, value);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] zoom,
                            input logic [CSR_DATA_W-1:0] fmt);
      wait_drained();
      write_csr(CSR_ZOOM, zoom);
      write_csr(CSR_FORMAT, fmt);
   endtask

   // random settings, extremes included, sometimes with junk in the upper bits
   task automatic random_config();
      logic [CSR_DATA_W-1:0] zoom;
      logic [CSR_DATA_W-1:0] fmt;
      case ($urandom_range(0, 6))
         0: zoom = 32'd1024;
         1: zoom = CSR_DATA_W'(ZOOM_UNITY) - 32'd1;
         2: zoom = CSR_DATA_W'(ZOOM_UNITY);
         3: zoom = 32'd4194304;
         4: zoom = $urandom_range(1024, 65535);
         5: zoom = $urandom_range(65536, 4194304);
         default: zoom = $urandom;
      endcase
      if ($urandom_range(0, 3) == 0)
         zoom = zoom | ($urandom << ZOOM_W);
      fmt = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0)
         fmt = fmt | ($urandom & ~32'h3);
      configure(zoom, fmt);
      if ($urandom_range(0, 7) == 0)
         write_csr($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom);
   endtask

   task automatic run_directed();
      // reset settings: unity zoom, bgra
      send_pixel(pixel_word(12'hFFF, 12'hFFF, 1'b0, 1'b1, 1'b1, '1, '1, '1, '1, 8'hFF));
      send_pixel(pixel_word(12'd0, 12'd0, 1'b1, 1'b0, 1'b0, 32'h00FF8010, '0, '0, '0, 8'h00));
      send_pixel(pixel_word(12'd8, 12'd0, 1'b1, 1'b0, 1'b0, 32'h00123456, '1, '1, '1, 8'h00));
      send_pixel(pixel_word(12'd100, 12'd9, 1'b1, 1'b1, 1'b1, 32'hFF123456, '0, '0, '0, 8'h00));
      send_pixel(pixel_word(12'hFFF, 12'd8, 1'b1, 1'b0, 1'b0, 32'h80FFFFFF, '1, '1, '1, 8'h00));
      send_pixel(pixel_word(12'd16, 12'd24, 1'b1, 1'b0, 1'b0, 32'h01FFFFFF, '0, '0, '0, 8'h00));
      send_pixel(pixel_word(12'd31, 12'd2, 1'b1, 1'b0, 1'b0, 32'hFE000000, '0, '0, '0, 8'h00));
      // writes to unused indexes leave the settings alone
      wait_drained();
      write_csr(CSR_SPARE_LO, '1);
      write_csr(CSR_SPARE_HI, 32'h0000_0001);
      send_pixel(pixel_word(12'd5, 12'd5, 1'b1, 1'b0, 1'b0, 32'hFF0000FF, '0, '0, '0, 8'h00));

      // lowest zoom, junk above the register width; bgra box average
      configure(32'hFF80_0400, CSR_DATA_W'(FMT_BGRA));
      send_pixel(pixel_word(12'd3, 12'd4, 1'b1, 1'b0, 1'b0, '1, '1, '1, '1, 8'h00));
      send_pixel(pixel_word(12'd9, 12'd4, 1'b1, 1'b0, 1'b0, 32'h00FFFFFF, 32'h00AA5511,
                            32'h00000000, 32'h00FFFFFF, 8'h00));
      send_pixel(pixel_word(12'd12, 12'd40, 1'b1, 1'b0, 1'b0, 32'h80102030, 32'h40FF0000,
                            32'hC0000000, 32'h7F0000FF, 8'h00));
      // colour is not averaged at the top row or left column
      send_pixel(pixel_word(12'd1, 12'd1, 1'b1, 1'b0, 1'b1, 32'hFF405060, '0, '0, '0, 8'hFF));
      send_pixel(pixel_word(12'd1, 12'd1, 1'b1, 1'b1, 1'b0, 32'h7F405060, '1, '1, '1, 8'hFF));

      // just below unity, gray: box, row edge, column edge, corner
      configure(CSR_DATA_W'(ZOOM_UNITY) - 32'd1, CSR_DATA_W'(FMT_GRAY));
      send_pixel(pixel_word(12'd0, 12'd0, 1'b1, 1'b0, 1'b0, 32'hABCDEF03, 32'h000000FF,
                            32'hFF0000FE, 32'h12345601, 8'h55));
      send_pixel(pixel_word(12'd0, 12'd0, 1'b1, 1'b0, 1'b1, 32'h000000FF, '0, '0, '0, 8'hFF));
      send_pixel(pixel_word(12'd0, 12'd0, 1'b1, 1'b1, 1'b0, 32'hFFFFFF00, '1, '1, '1, 8'h01));
      send_pixel(pixel_word(12'd0, 12'd0, 1'b1, 1'b1, 1'b1, 32'h00000010, '0, '0, '0, 8'h21));

      // unity gray: high bytes and edge ignored
      configure(CSR_DATA_W'(ZOOM_UNITY), CSR_DATA_W'(FMT_GRAY));
      send_pixel(pixel_word(12'd7, 12'd7, 1'b1, 1'b0, 1'b1, 32'hFFFFFF7F, '0, '0, '0, 8'h00));

      // highest zoom, bgr: alpha byte ignored
      configure(32'd4194304, CSR_DATA_W'(FMT_BGR));
      send_pixel(pixel_word(12'd2, 12'd3, 1'b1, 1'b0, 1'b0, 32'h00A0B0C0, '1, '1, '1, 8'hFF));
      send_pixel(pixel_word(12'd2, 12'd3, 1'b0, 1'b0, 1'b0, 32'h00A0B0C0, '1, '1, '1, 8'hFF));

      // bgr box average
      configure(32'd1024, CSR_DATA_W'(FMT_BGR));
      send_pixel(pixel_word(12'd2, 12'd3, 1'b1, 1'b0, 1'b0, 32'h12FF00FF, 32'h34FF00FE,
                            32'h5601FF00, 32'h7803FF01, 8'h00));

      // unsupported format through junk in the upper data bits
      configure(CSR_DATA_W'(ZOOM_UNITY), 32'hFFFF_FFFF);
      send_pixel(pixel_word(12'd7, 12'd7, 1'b1, 1'b0, 1'b0, 32'hFF112233, '0, '0, '0, 8'h00));
      send_pixel(pixel_word(12'd8, 12'd7, 1'b1, 1'b0, 1'b0, 32'hFF112233, '0, '0, '0, 8'h00));
      send_pixel(pixel_word(12'd8, 12'd7, 1'b0, 1'b0, 1'b0, 32'hFF112233, '0, '0, '0, 8'h00));
   endtask

   // receiver ready: random stalls, plus a long hold-off on request
   initial begin
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_cycles > 0) begin
            rsp_bus.ready = 1'b0;
            long_hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else if (rsp_idling && $urandom_range(0, 99) < 20) begin
            rsp_bus.ready = 1'b0;
            stall_left    = pick_gap() - 1;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         board.check_response({rsp_bus.out_blue, rsp_bus.out_green, rsp_bus.out_red,
                               rsp_bus.out_alpha});
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // main sequence
   initial begin
      int remaining;
      int phase_len;
      board = new();
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.screen_x     = '0;
      req_bus.screen_y     = '0;
      req_bus.in_bounds    = 1'b0;
      req_bus.src_col_zero = 1'b0;
      req_bus.src_row_zero = 1'b0;
      req_bus.px_cur       = '0;
      req_bus.px_left      = '0;
      req_bus.px_up        = '0;
      req_bus.px_up_left   = '0;
      req_bus.px_edge      = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = CSR_ZOOM;
      csr_bus.data         = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();

      // receiver holds off while words keep coming, so the input stalls
      random_config();
      req_idling       = 1'b0;
      rsp_idling       = 1'b1;
      long_hold_cycles = LONG_HOLD;
      for (int n = 0; n < PRESSURE_RUN; n++)
         send_pixel(random_request());
      // sender pauses until everything is back
      wait_drained();
      remaining = RANDOM_ITEMS - PRESSURE_RUN;

      // random phases, each under fresh settings and idling
      while (remaining > 0) begin
         random_config();
         req_idling = $urandom_range(0, 3) != 0;
         rsp_idling = $urandom_range(0, 3) != 0;
         phase_len  = $urandom_range(80, 160);
         if (phase_len > remaining)
            phase_len = remaining;
         for (int n = 0; n < phase_len; n++) begin
            if (n == phase_len / 2 && $urandom_range(0, 2) == 0)
               wait_drained();
            send_pixel(random_request());
         end
         remaining -= phase_len;
      end

      wait_drained();
      if (board.mismatches == 0 && board.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/pcac_pkg.sv
hw/rtl/pcac_if.sv
hw/rtl/pcac_pixel.sv
hw/rtl/pcac_csr.sv
hw/rtl/pixel_checkerboard_alpha_compositor.sv
bench/pixel_checkerboard_alpha_compositor_tb.sv
